@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of the array block.
// No dependencies; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at each rising clock edge outside reset.
`define AST_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("property violated");

// Condition that must never be seen outside reset.
`define AST_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ hw/rtl/pida_pkg.sv @@
// Package for the positional insert/delete array: codes, widths, control struct.
// No dependencies; used by every module of the block and by its checker.
package pida_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int FUNC_W          = 2;
  localparam int VAL_W           = 32;
  localparam int ST_W            = 2;
  localparam int CFG_W           = 5;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_W-1:0] INIT_CAP_RST = CFG_W'(5);
  localparam logic [CFG_W-1:0] GROW_RST     = CFG_W'(5);

  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] OP_DELETE = 2'd2;
  localparam logic [FUNC_W-1:0] OP_READ   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW     = 1'b1;

  typedef struct packed {
    logic exec;
  } pida_cmd_t;

  function automatic int cnt_w(input int max_entries);
    return $clog2(max_entries + 1);
  endfunction

  function automatic int s_data_w(input int max_entries);
    return ((cnt_w(max_entries) + VAL_W + 7) / 8) * 8;
  endfunction

  function automatic int m_data_w(input int max_entries);
    return ((ST_W + 2 * cnt_w(max_entries) + VAL_W + 7) / 8) * 8;
  endfunction

endpackage

@@ hw/rtl/pida_ctrl.sv @@
// Controller of the array block: input/output handshake and result word flag.
// Depends on pida_pkg.
module pida_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output pida_pkg::pida_cmd_t cmd
);
  import pida_pkg::*;

  typedef enum logic {
    CS_EMPTY,
    CS_LOADED
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == CS_EMPTY) || m_tready;
  assign m_tvalid = (state == CS_LOADED);
  assign cmd.exec = s_tvalid && s_tready;

  always_comb begin
    case (state)
      CS_EMPTY:  state_next = cmd.exec ? CS_LOADED : CS_EMPTY;
      CS_LOADED: state_next = (m_tready && !cmd.exec) ? CS_EMPTY : CS_LOADED;
      default:   state_next = CS_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_EMPTY;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/pida_dp.sv @@
// Datapath of the array block: element cells, count, capacity, result word.
// Depends on pida_pkg; driven by pida_ctrl through a command struct.
module pida_dp #(
  parameter int MAX_ENTRIES = pida_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  pida_pkg::pida_cmd_t                        cmd,
  input  logic [pida_pkg::FUNC_W-1:0]                func,
  input  logic [pida_pkg::cnt_w(MAX_ENTRIES)-1:0]    position,
  input  logic signed [pida_pkg::VAL_W-1:0]          value,
  input  logic                                       cfg_we,
  input  logic [pida_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [pida_pkg::CFG_W-1:0]                 cfg_data,
  output logic [pida_pkg::ST_W-1:0]                  status,
  output logic [pida_pkg::cnt_w(MAX_ENTRIES)-1:0]    count,
  output logic [pida_pkg::cnt_w(MAX_ENTRIES)-1:0]    capacity,
  output logic signed [pida_pkg::VAL_W-1:0]          read_value
);
  import pida_pkg::*;

  localparam int CNT_W = cnt_w(MAX_ENTRIES);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SUM_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ENTRIES);
  localparam logic [SUM_W-1:0] MAX_S = SUM_W'(MAX_ENTRIES);

  logic signed [VAL_W-1:0] elems [MAX_ENTRIES];
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cap;
  logic [CFG_W-1:0]        step;

  logic [CNT_W-1:0]        cnt_next;
  logic [CNT_W-1:0]        cap_next;
  logic [ST_W-1:0]         st_next;
  logic signed [VAL_W-1:0] rd_next;
  logic [CNT_W-1:0]        ins_pos;
  logic                    do_ins;
  logic                    do_del;
  logic [CNT_W-1:0]        after;
  logic [SUM_W-1:0]        grow_sum;
  logic [CNT_W-1:0]        grow_cap;
  logic [CNT_W-1:0]        grown;
  logic [CNT_W-1:0]        set_cap;
  logic [CNT_W-1:0]        cfg_cap;

  // capacity after growth by the step, capped, and at least the new count
  assign after    = cnt + CNT_W'(1);
  assign grow_sum = SUM_W'(cap) + SUM_W'(step);
  assign grow_cap = (grow_sum > MAX_S) ? MAX_C : grow_sum[CNT_W-1:0];
  assign grown    = (grow_cap < after) ? after : grow_cap;

  // capacity from a setting write, capped and at least the count
  assign set_cap = (SUM_W'(cfg_data) > MAX_S) ? MAX_C : CNT_W'(cfg_data);
  assign cfg_cap = (set_cap < cnt) ? cnt : set_cap;

  assign ins_pos = (func == OP_APPEND) ? cnt : position;

  always_comb begin
    st_next  = ST_OK;
    cnt_next = cnt;
    cap_next = cap;
    rd_next  = '0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    case (func)
      OP_INSERT, OP_APPEND: begin
        if (ins_pos > cnt) begin
          st_next = ST_BAD_INDEX;
        end else if (cnt == MAX_C) begin
          st_next = ST_FULL;
        end else begin
          do_ins   = 1'b1;
          cnt_next = after;
          if (after > cap) begin
            cap_next = grown;
          end
        end
      end
      OP_DELETE: begin
        if (position >= cnt) begin
          st_next = ST_BAD_INDEX;
        end else begin
          do_del   = 1'b1;
          cnt_next = cnt - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (position < cnt) begin
          rd_next = elems[position[IDX_W-1:0]];
        end else begin
          st_next = ST_BAD_INDEX;
        end
      end
      default: st_next = ST_BAD_INDEX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      cap  <= (SUM_W'(INIT_CAP_RST) > MAX_S) ? MAX_C : CNT_W'(INIT_CAP_RST);
      step <= GROW_RST;
    end else if (cmd.exec) begin
      cnt <= cnt_next;
      cap <= cap_next;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INIT_CAP: cap  <= cfg_cap;
        CFG_GROW:     step <= cfg_data;
        default:      step <= step;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status     <= st_next;
      count      <= cnt_next;
      capacity   <= cap_next;
      read_value <= rd_next;
    end
  end

  // each cell takes its lower neighbor on insert, its upper neighbor on delete
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.exec && do_ins) begin
        if (CNT_W'(g) == ins_pos) begin
          elems[g] <= value;
        end else if (CNT_W'(g) > ins_pos) begin
          if (g > 0) begin
            elems[g] <= elems[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (cmd.exec && do_del) begin
        if (CNT_W'(g) >= position) begin
          if (g < MAX_ENTRIES - 1) begin
            elems[g] <= elems[(g < MAX_ENTRIES - 1) ? g + 1 : g];
          end
        end
      end
    end
  end

endmodule

@@ hw/rtl/positional_insert_delete_array.sv @@
// Positional insert/delete array: ordered store of signed 32-bit elements.
// The result word is registered on input accept and is valid in the cycle after it.
// Throughput: one word per cycle while m_tready is high; inserts and deletes shift cells in parallel.
// A result held with m_tready low stalls the input side.
// Reset (synchronous): count zero, capacity min(5, MAX_ENTRIES), step 5;
// element contents are undefined until written.
module positional_insert_delete_array #(
  parameter int MAX_ENTRIES = pida_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // position, value, zero fill
  input  logic [pida_pkg::s_data_w(MAX_ENTRIES)-1:0]    s_tdata,
  // func
  input  logic [pida_pkg::FUNC_W-1:0]                   s_tuser,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // status, count, capacity, read_value, zero fill
  output logic [pida_pkg::m_data_w(MAX_ENTRIES)-1:0]    m_tdata,
  input  logic                                          cfg_we,
  input  logic [pida_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [pida_pkg::CFG_W-1:0]                    cfg_data
);
  import pida_pkg::*;

  localparam int CNT_W = cnt_w(MAX_ENTRIES);
  localparam int M_W   = m_data_w(MAX_ENTRIES);

  pida_cmd_t               cmd;
  logic [ST_W-1:0]         status;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        capacity;
  logic signed [VAL_W-1:0] read_value;

  pida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  pida_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .func       (s_tuser),
    .position   (s_tdata[CNT_W-1:0]),
    .value      (s_tdata[CNT_W +: VAL_W]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .status     (status),
    .count      (count),
    .capacity   (capacity),
    .read_value (read_value)
  );

  assign m_tdata = M_W'({read_value, capacity, count, status});

endmodule

@@ hw/rtl/pida_chk.sv @@
// Port checker for the positional insert/delete array, bound to the top level.
// Depends on pida_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pida_chk #(
  parameter int MAX_ENTRIES = pida_pkg::MAX_ENTRIES_DEF
) (
  input logic                                          clk,
  input logic                                          rst,
  input logic                                          s_tvalid,
  input logic                                          s_tready,
  input logic [pida_pkg::s_data_w(MAX_ENTRIES)-1:0]    s_tdata,
  input logic [pida_pkg::FUNC_W-1:0]                   s_tuser,
  input logic                                          m_tvalid,
  input logic                                          m_tready,
  input logic [pida_pkg::m_data_w(MAX_ENTRIES)-1:0]    m_tdata,
  input logic                                          cfg_we,
  input logic [pida_pkg::CFG_IDX_W-1:0]                cfg_index,
  input logic [pida_pkg::CFG_W-1:0]                    cfg_data
);
  import pida_pkg::*;

  localparam int CNT_W = cnt_w(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ENTRIES);

  logic [ST_W-1:0]  o_status;
  logic [CNT_W-1:0] o_count;
  logic [CNT_W-1:0] o_cap;

  assign o_status = m_tdata[ST_W-1:0];
  assign o_count  = m_tdata[ST_W +: CNT_W];
  assign o_cap    = m_tdata[ST_W + CNT_W +: CNT_W];

  `AST_HOLDS(a_out_holds, clk, rst, m_tvalid && !m_tready |=> m_tvalid)
  `AST_HOLDS(a_accept_gives_word, clk, rst, s_tvalid && s_tready |=> m_tvalid)
  `AST_NEVER(a_count_over_cap, clk, rst, m_tvalid && (o_count > o_cap))
  `AST_NEVER(a_full_not_at_max, clk, rst, m_tvalid && o_status == ST_FULL && o_count != MAX_C)

endmodule

bind positional_insert_delete_array pida_chk #(.MAX_ENTRIES(MAX_ENTRIES)) u_pida_chk (.*);
